FILE: rtl/stlsc_pkg.sv
// shared types, constants and helpers for the limit switch calibration block
`default_nettype none

package stlsc_pkg;

	// counter width of the travel and run counters
	localparam int COUNT_WIDTH = 24;
	localparam int PROD_WIDTH  = COUNT_WIDTH + 16;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// register file
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MARGIN_STEPS  = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE_Q16 = 1'd1;
	localparam logic [15:0] MARGIN_RESET    = 16'd500;
	localparam logic [15:0] TOLERANCE_RESET = 16'd328;

	// calibration stages
	localparam logic [2:0] STAGE_SEEK    = 3'd0;
	localparam logic [2:0] STAGE_MEASURE = 3'd1;
	localparam logic [2:0] STAGE_VERIFY  = 3'd2;
	localparam logic [2:0] STAGE_OFFSET  = 3'd3;
	localparam logic [2:0] STAGE_HOME    = 3'd4;

	typedef struct packed {
		logic limit_min;
		logic limit_max;
	} in_word_t;

	typedef struct packed {
		logic        run_step;
		logic        halt_pulse;
		logic        direction;
		logic [2:0]  stage_now;
		logic        done_res;
		logic        restarted;
		logic [23:0] travel_steps;
	} out_word_t;

	typedef struct packed {
		logic [15:0] margin_steps;
		logic [15:0] tolerance_q16;
	} cfg_t;

	typedef struct packed {
		logic [2:0]             stage;
		logic [COUNT_WIDTH-1:0] travel_count;
		logic [COUNT_WIDTH-1:0] run_count;
		logic                   far_side;
		logic                   dir;
		logic                   done;
	} cal_state_t;

	// saturating increment
	function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
		return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	// subtract clamped at zero
	function automatic logic [COUNT_WIDTH-1:0] sat_sub(input logic [COUNT_WIDTH-1:0] a,
		input logic [COUNT_WIDTH-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/stlsc_cfg.sv
// configuration registers: margin and tolerance
`default_nettype none

module stlsc_cfg (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [stlsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [stlsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	output stlsc_pkg::cfg_t                            cfg
);
	import stlsc_pkg::*;

	logic [15:0] margin_q;
	logic [15:0] tolerance_q;

	// register writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q    <= MARGIN_RESET;
			tolerance_q <= TOLERANCE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MARGIN_STEPS:  margin_q    <= cfg_data;
				REG_TOLERANCE_Q16: tolerance_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.margin_steps  = margin_q;
	assign cfg.tolerance_q16 = tolerance_q;

endmodule

`default_nettype wire

FILE: rtl/stlsc_step.sv
// per-tick next-state and result logic of the calibration sequence
`default_nettype none

module stlsc_step (
	input  wire stlsc_pkg::cal_state_t st,
	input  wire stlsc_pkg::cfg_t       cfg,
	input  wire stlsc_pkg::in_word_t   in_word,
	output stlsc_pkg::cal_state_t      st_next,
	output stlsc_pkg::out_word_t       res
);
	import stlsc_pkg::*;

	logic                   any_sw;
	logic                   opposite;
	logic [COUNT_WIDTH-1:0] run_inc;
	logic [COUNT_WIDTH-1:0] travel_inc;
	logic [COUNT_WIDTH-1:0] margin_ext;
	logic [COUNT_WIDTH-1:0] travel_less;
	logic [COUNT_WIDTH-1:0] diff;
	logic [PROD_WIDTH-1:0]  limit_prod;
	logic [PROD_WIDTH-1:0]  diff_sh;
	logic                   mismatch;
	logic                   reached;
	logic                   run_o;
	logic                   halt_o;
	logic                   restart_o;

	// switch decode
	assign any_sw   = in_word.limit_min | in_word.limit_max;
	assign opposite = (st.far_side & in_word.limit_min) | (~st.far_side & in_word.limit_max);

	// counter arithmetic
	assign run_inc     = sat_inc(st.run_count);
	assign travel_inc  = sat_inc(st.travel_count);
	assign margin_ext  = COUNT_WIDTH'(cfg.margin_steps);
	assign travel_less = sat_sub(st.travel_count, margin_ext);
	assign reached     = (run_inc >= st.travel_count);

	// mismatch check: |run - travel| * 65536 > travel * tolerance
	assign diff       = (run_inc > st.travel_count) ? run_inc - st.travel_count
	                                                : st.travel_count - run_inc;
	assign limit_prod = PROD_WIDTH'(st.travel_count) * PROD_WIDTH'(cfg.tolerance_q16);
	assign diff_sh    = {diff, 16'd0};
	assign mismatch   = (diff_sh > limit_prod);

	// stage actions
	always_comb begin
		st_next   = st;
		run_o     = 1'b0;
		halt_o    = 1'b0;
		restart_o = 1'b0;
		if (!st.done) begin
			unique case (st.stage)
				STAGE_MEASURE: begin
					run_o = 1'b1;
					halt_o = any_sw;
					st_next.travel_count = travel_inc;
					if (opposite) begin
						st_next.dir      = ~st.dir;
						halt_o           = 1'b1;
						st_next.far_side = in_word.limit_max;
						st_next.stage    = STAGE_VERIFY;
					end
				end
				STAGE_VERIFY: begin
					run_o = 1'b1;
					halt_o = any_sw;
					st_next.run_count = run_inc;
					if (opposite) begin
						st_next.dir      = ~st.dir;
						st_next.far_side = in_word.limit_max;
						st_next.run_count = '0;
						if (mismatch) begin
							st_next.stage        = STAGE_SEEK;
							st_next.travel_count = '0;
							restart_o            = 1'b1;
						end else begin
							st_next.travel_count = travel_less;
							st_next.stage        = STAGE_OFFSET;
						end
					end
				end
				STAGE_OFFSET: begin
					run_o = 1'b1;
					halt_o = any_sw;
					st_next.run_count = run_inc;
					if (reached) begin
						st_next.travel_count = travel_less;
						st_next.dir          = ~st.dir;
						if (!st.far_side) begin
							st_next.done = 1'b1;
						end else begin
							st_next.run_count = '0;
							st_next.stage     = STAGE_HOME;
						end
					end
				end
				STAGE_HOME: begin
					run_o = 1'b1;
					halt_o = any_sw;
					st_next.run_count = run_inc;
					if (reached) begin
						st_next.dir  = ~st.dir;
						st_next.done = 1'b1;
					end
				end
				default: begin
					// seek, unused codes behave the same
					if (!any_sw) begin
						run_o = 1'b1;
					end else begin
						st_next.far_side = in_word.limit_max;
						st_next.dir      = ~in_word.limit_max;
						halt_o           = 1'b1;
						st_next.stage    = STAGE_MEASURE;
					end
				end
			endcase
		end
	end

	// result word reports the state after the tick
	always_comb begin
		res.run_step     = run_o;
		res.halt_pulse   = halt_o;
		res.direction    = st_next.dir;
		res.stage_now    = st_next.stage;
		res.done_res     = st_next.done;
		res.restarted    = restart_o;
		res.travel_steps = 24'(st_next.travel_count);
	end

endmodule

`default_nettype wire

FILE: rtl/stepper_limit_switch_calibration_core.sv
// top level of the stepper limit switch travel calibration block
//
//  channel   dir   handshake                word
//  in        in    in_valid / in_ready      in_data   (limit_min, limit_max)
//  out       out   out_valid / out_ready    out_data  (run_step .. travel_steps)
//  cfg       in    cfg_we                   cfg_index, cfg_data
//
// one word per cycle sustained while out_ready is high; a word is held in the input register
// and its result is then registered in the output register
// the calibration state advances when the input register word moves into the
// output register; the output register and input register together hold two words
// reset clears stage, counters, direction and done; config returns to 500 / 328
// a stalled output holds the state; the input register still takes one more word
`default_nettype none

module stepper_limit_switch_calibration_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire stlsc_pkg::in_word_t                   in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output stlsc_pkg::out_word_t                       out_data,
	input  wire logic                                  cfg_we,
	input  wire logic [stlsc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [stlsc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import stlsc_pkg::*;

	cfg_t       cfg;
	cal_state_t st_q;
	cal_state_t st_next;
	out_word_t  res;
	in_word_t   in_word_s1;
	logic       in_valid_s1;
	out_word_t  out_word_s2;
	logic       out_valid_s2;
	logic       advance;

	stlsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	stlsc_step u_step (
		.st      (st_q),
		.cfg     (cfg),
		.in_word (in_word_s1),
		.st_next (st_next),
		.res     (res)
	);

	// output register free or draining this cycle
	assign advance  = ~out_valid_s2 | out_ready;
	assign in_ready = ~in_valid_s1 | advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			in_word_s1 <= in_data;
		end
	end

	// calibration state, moves with each processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance && in_valid_s1) begin
			st_q <= st_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid_s1) begin
			out_word_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_word_s2;

endmodule

`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the stepper limit switch calibration core
`timescale 1ns / 100ps

module tb;
	import stlsc_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 80;
	localparam int PHASE_TICKS = 180;

	// predicted axis state, kept at the block's widths
	typedef struct packed {
		logic [2:0]             stage;
		logic [COUNT_WIDTH-1:0] travel;
		logic [COUNT_WIDTH-1:0] run;
		logic                   far;
		logic                   dir;
		logic                   done;
	} axis_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

	axis_t axis = '0;
	logic [15:0] margin_set = MARGIN_RESET;
	logic [15:0] tol_set = TOLERANCE_RESET;
	out_word_t predicted_status[$];

	int mismatch_count = 0;
	int active_ticks = 0;
	int cycle_count = 0;
	bit idle_on = 1'b1;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	stepper_limit_switch_calibration_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stepper_limit_switch_calibration_core regression: fail");
			$finish;
		end
	end

	function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] v);
		return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] less_margin(input logic [COUNT_WIDTH-1:0] v);
		return (v > margin_set) ? v - margin_set : '0;
	endfunction

	// one tick of the calibration sequence
	function automatic out_word_t advance_axis(inout axis_t s, input in_word_t w);
		out_word_t r;
		logic pressed;
		logic opposite;
		logic [COUNT_WIDTH-1:0] gap;
		logic [PROD_WIDTH-1:0] lhs;
		logic [PROD_WIDTH-1:0] rhs;
		pressed  = w.limit_min | w.limit_max;
		opposite = s.far ? w.limit_min : w.limit_max;
		r = '0;
		if (!s.done) begin
			case (s.stage)
				STAGE_MEASURE: begin
					r.run_step   = 1'b1;
					r.halt_pulse = pressed;
					s.travel = count_up(s.travel);
					if (opposite) begin
						s.dir = ~s.dir;
						r.halt_pulse = 1'b1;
						s.far = w.limit_max;
						s.stage = STAGE_VERIFY;
					end
				end
				STAGE_VERIFY: begin
					r.run_step   = 1'b1;
					r.halt_pulse = pressed;
					s.run = count_up(s.run);
					if (opposite) begin
						s.dir = ~s.dir;
						s.far = w.limit_max;
						gap = (s.run > s.travel) ? s.run - s.travel : s.travel - s.run;
						lhs = {gap, 16'h0000};
						rhs = s.travel;
						rhs = rhs * tol_set;
						if (lhs > rhs) begin
							// counts disagree: start over from seek
							s.stage = STAGE_SEEK;
							s.run = '0;
							s.travel = '0;
							r.restarted = 1'b1;
						end else begin
							s.travel = less_margin(s.travel);
							s.run = '0;
							s.stage = STAGE_OFFSET;
						end
					end
				end
				STAGE_OFFSET: begin
					r.run_step   = 1'b1;
					r.halt_pulse = pressed;
					s.run = count_up(s.run);
					if (s.run >= s.travel) begin
						s.travel = less_margin(s.travel);
						s.dir = ~s.dir;
						if (!s.far) begin
							s.done = 1'b1;
						end else begin
							s.run = '0;
							s.stage = STAGE_HOME;
						end
					end
				end
				STAGE_HOME: begin
					r.run_step   = 1'b1;
					r.halt_pulse = pressed;
					s.run = count_up(s.run);
					if (s.run >= s.travel) begin
						s.dir = ~s.dir;
						s.done = 1'b1;
					end
				end
				default: begin
					// seek, and any unused stage code
					if (!pressed) begin
						r.run_step = 1'b1;
					end else begin
						s.far = w.limit_max;
						s.dir = ~w.limit_max;
						r.halt_pulse = 1'b1;
						s.stage = STAGE_MEASURE;
					end
				end
			endcase
		end
		r.direction    = s.dir;
		r.stage_now    = s.stage;
		r.done_res     = s.done;
		r.travel_steps = s.travel[23:0];
		return r;
	endfunction

	// what a word would do, without committing it
	function automatic out_word_t preview(input in_word_t w);
		axis_t scratch;
		scratch = axis;
		return advance_axis(scratch, w);
	endfunction

	function automatic in_word_t levels(input logic mn, input logic mx);
		in_word_t w;
		w.limit_min = mn;
		w.limit_max = mx;
		return w;
	endfunction

	// press on the switch opposite the last one seen
	function automatic in_word_t far_word(input logic both);
		return axis.far ? levels(1'b1, both) : levels(both, 1'b1);
	endfunction

	// status checker and output ready pattern
	always @(posedge clk) begin : status_sink
		out_word_t want;
		if (out_valid && out_ready) begin
			if (predicted_status.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected status word: stage=%0d travel=%0d",
						out_data.stage_now, out_data.travel_steps);
			end else begin
				want = predicted_status.pop_front();
				if (out_data.run_step !== want.run_step ||
					out_data.halt_pulse !== want.halt_pulse ||
					out_data.direction !== want.direction ||
					out_data.stage_now !== want.stage_now ||
					out_data.done_res !== want.done_res ||
					out_data.restarted !== want.restarted ||
					out_data.travel_steps !== want.travel_steps) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("status mismatch at cycle %0d", cycle_count);
						$display("  expected run=%0b halt=%0b dir=%0b stage=%0d done=%0b rst=%0b trv=%0d",
							want.run_step, want.halt_pulse, want.direction, want.stage_now,
							want.done_res, want.restarted, want.travel_steps);
						$display("  actual   run=%0b halt=%0b dir=%0b stage=%0d done=%0b rst=%0b trv=%0d",
							out_data.run_step, out_data.halt_pulse, out_data.direction,
							out_data.stage_now, out_data.done_res, out_data.restarted,
							out_data.travel_steps);
					end
				end
			end
		end
		// long hold on request, otherwise short random stalls
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// offer one word, wait for it to be taken, predict its status
	task automatic send_word(input in_word_t w);
		int gap;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		if (!axis.done)
			active_ticks++;
		predicted_status.push_back(advance_axis(axis, w));
	endtask

	// sender stops and waits for every status word
	task automatic drain_results();
		in_valid <= 1'b0;
		while (predicted_status.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [15:0] margin, input logic [15:0] tol);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MARGIN_STEPS;
		cfg_data  <= margin;
		@(posedge clk);
		margin_set = margin;
		cfg_index <= REG_TOLERANCE_Q16;
		cfg_data  <= tol;
		@(posedge clk);
		tol_set = tol;
		cfg_we <= 1'b0;
	endtask

	// running tick, now and then pressing the switch being left
	task automatic filler_tick(input int noise_pct);
		if ($urandom_range(0, 99) < noise_pct)
			send_word(axis.far ? levels(1'b0, 1'b1) : levels(1'b1, 1'b0));
		else
			send_word(levels(1'b0, 1'b0));
	endtask

	// bring the axis back to seek through a forced restart
	task automatic steer_to_seek();
		in_word_t w;
		out_word_t probe;
		while (axis.stage != STAGE_SEEK) begin
			w = far_word(1'b0);
			probe = preview(w);
			if (axis.stage == STAGE_VERIFY && !probe.restarted)
				filler_tick(0);
			else
				send_word(w);
		end
	endtask

	// one seek / measure / verify pass; settle lets it go on to the offset run
	task automatic calib_pass(input int meas_len, input bit settle, input int noise_pct,
		input int seek_pick);
		longint n;
		longint slack;
		longint m;
		longint k;
		in_word_t w;
		out_word_t probe;
		repeat ($urandom_range(0, 3)) send_word(levels(1'b0, 1'b0));
		case (seek_pick)
			0: send_word(levels(1'b1, 1'b0));
			1: send_word(levels(1'b0, 1'b1));
			default: send_word(levels(1'b1, 1'b1));
		endcase
		repeat (meas_len - 1) filler_tick(noise_pct);
		send_word(far_word(!settle && $urandom_range(0, 7) == 0));
		// return run length relative to the measured travel
		n = axis.travel;
		slack = (n * tol_set) >> 16;
		if (settle)
			m = ($urandom_range(0, 1) == 1 && n > slack) ? n - slack : n + slack;
		else if ($urandom_range(0, 1) == 1)
			m = n - slack - 1 - $urandom_range(0, 2);
		else
			m = n + slack + 1 + $urandom_range(0, 2);
		if (m < 1)
			m = n + slack + 1;
		for (k = 1; k < m; k++)
			filler_tick(noise_pct);
		if (settle) begin
			send_word(far_word(1'b0));
		end else begin
			w = far_word($urandom_range(0, 7) == 0);
			probe = preview(w);
			while (!probe.restarted) begin
				filler_tick(noise_pct);
				probe = preview(w);
			end
			send_word(w);
		end
	endtask

	// random switch levels, kept short of the offset run
	task automatic noise_run(input int count);
		in_word_t w;
		out_word_t probe;
		repeat (count) begin
			w = levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			probe = preview(w);
			if (probe.stage_now == STAGE_OFFSET || probe.done_res)
				w = levels(1'b0, 1'b0);
			send_word(w);
		end
		steer_to_seek();
	endtask

	// both switches, single switches, switch chatter, three restarts
	task automatic test_directed_sequence();
		logic [33:0] script;
		int i;
		script = 34'b0011010010101110010110011100000110;
		for (i = 16; i >= 0; i--)
			send_word(in_word_t'(script[2*i +: 2]));
		drain_results();
	endtask

	// zero and full scale tolerance and margin
	task automatic test_tolerance_extremes();
		set_config(16'd0, 16'd0);
		repeat (6) calib_pass($urandom_range(1, 24), 1'b0, 20, $urandom_range(0, 2));
		drain_results();
		set_config(16'hFFFF, 16'hFFFF);
		repeat (6) calib_pass($urandom_range(1, 24), 1'b0, 20, $urandom_range(0, 2));
		drain_results();
	endtask

	// random settings, restart passes with noise, some raw switch chatter
	task automatic test_random_passes();
		int pidx;
		int start_ticks;
		int len;
		for (pidx = 0; pidx < 6; pidx++) begin
			set_config(16'($urandom_range(0, 65535)),
				16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
					: $urandom_range(0, 8000)));
			idle_on = (pidx != 2);
			start_ticks = active_ticks;
			while (active_ticks - start_ticks < PHASE_TICKS) begin
				if ($urandom_range(0, 7) == 0) begin
					noise_run($urandom_range(4, 30));
				end else begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
					calib_pass(len, 1'b0, $urandom_range(0, 30), $urandom_range(0, 2));
				end
			end
			drain_results();
		end
		idle_on = 1'b1;
	endtask

	// output held off while words keep coming, so the input stalls
	task automatic test_output_holdoff();
		idle_on = 1'b0;
		hold_token <= hold_token + 1;
		calib_pass(24, 1'b0, 10, $urandom_range(0, 2));
		calib_pass(16, 1'b0, 10, $urandom_range(0, 2));
		drain_results();
	endtask

	// full run to done with the home leg, margin eating the last distance,
	// then words after done
	task automatic test_calibration_complete();
		idle_on = 1'b0;
		set_config(16'd20, 16'd6553);
		calib_pass($urandom_range(30, 40), 1'b1, 10, 1);
		while (!axis.done) filler_tick(15);
		repeat (24) send_word(levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
		drain_results();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sequence();
		test_tolerance_extremes();
		test_random_passes();
		test_output_holdoff();
		test_calibration_complete();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && predicted_status.size() == 0)
			$display("stepper_limit_switch_calibration_core regression: pass");
		else
			$display("stepper_limit_switch_calibration_core regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/stlsc_pkg.sv
rtl/stlsc_cfg.sv
rtl/stlsc_step.sv
rtl/stepper_limit_switch_calibration_core.sv
dv/tb.sv
